// ----- hw/rtl/nearest_site_search_macros.svh -----
// Assertion macros for the nearest site search block.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef NEAREST_SITE_SEARCH_MACROS_SVH
`define NEAREST_SITE_SEARCH_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define NSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/nss_pkg.sv -----
// Shared types and constants for the nearest site search block.
// No dependencies; imported by nss_dist, nss_best, the top level and the sim files.
package nss_pkg;

    localparam int MAX_SITES   = 256;
    localparam int COORD_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(MAX_SITES);
    localparam int CNT_BITS    = $clog2(MAX_SITES + 1);
    localparam int INDEX_BITS  = 8;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int DIST_BITS   = SQ_BITS + 1;
    localparam int SITE_BITS   = 2 * COORD_BITS;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                          func;
        logic [INDEX_BITS-1:0]         site_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] nearest_index;
        logic                  no_sites;
    } t_out_item;

    // One distance candidate leaving the distance pipeline.
    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] index;
        logic [DIST_BITS-1:0] sq_dist;
    } t_cand;

endpackage

// ----- hw/rtl/nearest_site_search.sv -----
// Nearest site search: a 256-entry table of signed 16-bit (x, y) sites held in
// one synchronous RAM, and a brute-force query that returns the index of the
// site closest to a point by exact squared Euclidean distance (lowest index on
// ties, no_sites set when the searched count is zero). A write item
// (func = 0) stores one site and gives no result. A query (func = 1) scans
// entries 0 .. sites_in_use-1 with one RAM read per cycle: the RAM read port
// sets the scan rate, and each read then passes through the RAM read register,
// three distance stages and the final compare. An empty query skips the scan.
// A new item is taken whenever no query is in progress, even while an earlier
// result still waits on the output register. The user must write sites_in_use
// through the configuration channel only while the block is idle; the block
// itself does not enforce this. Values above 256 search all 256 entries.
// Reading an entry that was never written returns whatever the RAM holds.
// Depends on nss_pkg, nss_ram, nss_dist, nss_best and the macros header.
`include "nearest_site_search_macros.svh"

module nearest_site_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nss_pkg::t_in_item             i_in_item,
    // result item channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nss_pkg::t_out_item            o_out_item,
    // configuration write channel (sites_in_use)
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nss_pkg::CNT_BITS-1:0]  i_cfg_data
);
    import nss_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} t_state;

    t_state                       r_state;
    logic [CNT_BITS-1:0]          r_sites_in_use;
    logic [CNT_BITS-1:0]          r_count;
    logic [CNT_BITS-1:0]          r_addr;
    logic                         r_empty;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic                         r_rd_valid;
    logic [ADDR_BITS-1:0]         r_rd_index;
    logic                         r_out_valid;
    t_out_item                    r_out_item;

    logic                         in_fire;
    logic                         wr_en;
    logic                         query_fire;
    logic                         rd_en;
    logic [CNT_BITS-1:0]          clamped_count;
    logic [SITE_BITS-1:0]         rd_data;
    logic signed [COORD_BITS-1:0] site_x, site_y;
    t_cand                        cand;
    logic                         dist_busy;
    logic                         best_have;
    logic [ADDR_BITS-1:0]         best_index;
    logic                         out_free;

    // Accept items only between queries; writes and queries never overlap, so
    // the RAM needs no forwarding: a write lands before any later scan reads.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign wr_en       = in_fire && (i_in_item.func == FUNC_WRITE)
                         && (CNT_BITS'(i_in_item.site_index) < CNT_BITS'(MAX_SITES));
    assign query_fire  = in_fire && (i_in_item.func == FUNC_QUERY);

    // Clamp the searched count to the table depth.
    assign clamped_count = (r_sites_in_use > CNT_BITS'(MAX_SITES))
                           ? CNT_BITS'(MAX_SITES) : r_sites_in_use;

    assign rd_en = (r_state == S_SCAN);

    nss_ram #(
        .WIDTH (SITE_BITS),
        .DEPTH (MAX_SITES)
    ) u_site_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_BITS'(i_in_item.site_index)),
        .i_wr_data ({i_in_item.coord_x, i_in_item.coord_y}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[ADDR_BITS-1:0]),
        .o_rd_data (rd_data)
    );

    assign site_x = rd_data[SITE_BITS-1:COORD_BITS];
    assign site_y = rd_data[COORD_BITS-1:0];

    nss_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_index (r_rd_index),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_sx    (site_x),
        .i_sy    (site_y),
        .o_cand  (cand),
        .o_busy  (dist_busy)
    );

    // Clear the running minimum as each query starts.
    nss_best u_best (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (query_fire),
        .i_cand       (cand),
        .o_have       (best_have),
        .o_best_index (best_index)
    );

    // The result register may be loaded when empty or being emptied.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sites_in_use <= '0;
            r_rd_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_addr         <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sites_in_use <= i_cfg_data;
            end
            // Tag each RAM read so the pipeline sees its data in the following cycle.
            r_rd_valid <= rd_en;
            // Load a finished result, or drop the one just taken.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (query_fire) begin
                        r_addr  <= '0;
                        r_count <= clamped_count;
                        r_empty <= (clamped_count == '0);
                        r_px    <= i_in_item.coord_x;
                        r_py    <= i_in_item.coord_y;
                        r_state <= (clamped_count == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Advance one entry per cycle; stop after the last in use.
                    r_addr <= r_addr + 1'b1;
                    if (r_addr + 1'b1 == r_count) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // Hold until the last candidate has been compared.
                    if (!r_rd_valid && !dist_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_item.no_sites      <= r_empty;
                        r_out_item.nearest_index <= r_empty ? '0 : INDEX_BITS'(best_index);
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        r_rd_index <= r_addr[ADDR_BITS-1:0];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Scan never reads past the searched count.
    `NSS_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN, r_addr < r_count, "scan beyond count")
    // A non-empty query always has a winner by the time its result is loaded.
    `NSS_ASSERT_NOW(a_done_has_best, (r_state == S_DONE) && !r_empty, best_have, "no best site")
    // Nothing stays in flight once the block is idle.
    `NSS_ASSERT_NOW(a_idle_quiet, r_state == S_IDLE, !dist_busy && !r_rd_valid, "busy while idle")
    // A loaded result always shows as valid in the next cycle.
    `NSS_ASSERT_NEXT(a_load_valid, (r_state == S_DONE) && out_free, o_out_valid, "result lost")

endmodule

// ----- hw/rtl/nss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/nss_dist.sv -----
// Three-stage squared distance pipeline: abs difference, squares, sum.
// Depends on nss_pkg.
module nss_dist (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [nss_pkg::ADDR_BITS-1:0]         i_index,
    input  logic signed [nss_pkg::COORD_BITS-1:0] i_px,
    input  logic signed [nss_pkg::COORD_BITS-1:0] i_py,
    input  logic signed [nss_pkg::COORD_BITS-1:0] i_sx,
    input  logic signed [nss_pkg::COORD_BITS-1:0] i_sy,
    output nss_pkg::t_cand                        o_cand,
    output logic                                  o_busy
);
    import nss_pkg::*;

    logic signed [COORD_BITS:0] dx_full;
    logic signed [COORD_BITS:0] dy_full;
    logic signed [COORD_BITS:0] dx_abs;
    logic signed [COORD_BITS:0] dy_abs;

    logic                  r_v1, r_v2, r_v3;
    logic [ADDR_BITS-1:0]  r_i1, r_i2, r_i3;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_BITS-1:0]    r_sqx, r_sqy;
    logic [DIST_BITS-1:0]  r_sum;

    // Differences are exact at one extra bit; magnitudes fit COORD_BITS.
    always_comb begin
        dx_full = {i_px[COORD_BITS-1], i_px} - {i_sx[COORD_BITS-1], i_sx};
        dy_full = {i_py[COORD_BITS-1], i_py} - {i_sy[COORD_BITS-1], i_sy};
        dx_abs  = dx_full[COORD_BITS] ? -dx_full : dx_full;
        dy_abs  = dy_full[COORD_BITS] ? -dy_full : dy_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_i1  <= i_index;
        r_dx  <= dx_abs[COORD_BITS-1:0];
        r_dy  <= dy_abs[COORD_BITS-1:0];
        r_i2  <= r_i1;
        r_sqx <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
        r_sqy <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
        r_i3  <= r_i2;
        r_sum <= DIST_BITS'(r_sqx) + DIST_BITS'(r_sqy);
    end

    assign o_cand.valid   = r_v3;
    assign o_cand.index   = r_i3;
    assign o_cand.sq_dist = r_sum;
    assign o_busy         = r_v1 | r_v2 | r_v3;

endmodule

// ----- hw/rtl/nss_best.sv -----
// Running minimum over distance candidates; strict compare keeps lowest index.
// Depends on nss_pkg.
module nss_best (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  nss_pkg::t_cand                i_cand,
    output logic                          o_have,
    output logic [nss_pkg::ADDR_BITS-1:0] o_best_index
);
    import nss_pkg::*;

    logic                 r_have;
    logic [ADDR_BITS-1:0] r_best_index;
    logic [DIST_BITS-1:0] r_best_dist;
    logic                 take;

    assign take = i_cand.valid && (!r_have || (i_cand.sq_dist < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have <= 1'b1;
        end
        if (take && !i_clear) begin
            r_best_index <= i_cand.index;
            r_best_dist  <= i_cand.sq_dist;
        end
    end

    assign o_have       = r_have;
    assign o_best_index = r_best_index;

endmodule

// ----- sim/nss_result_checker.sv -----
// Result checker for the nearest site search block: watches the three channels,
// predicts each query result from its own copy of the site table and count.
// Depends on nss_pkg for the item types and table dimensions.
module nss_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  nss_pkg::t_in_item            i_in_item,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  nss_pkg::t_out_item           i_out_item,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [nss_pkg::CNT_BITS-1:0] i_cfg_data,
    output int                           o_pending,
    output int                           o_fail_count
);
    import nss_pkg::*;

    logic signed [COORD_BITS-1:0] site_x [MAX_SITES];
    logic signed [COORD_BITS-1:0] site_y [MAX_SITES];
    logic [CNT_BITS-1:0]          search_count;
    t_out_item                    want_results [$];
    int                           fails = 0;

    assign o_fail_count = fails;

    function automatic logic [DIST_BITS-1:0] squared_gap(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy
    );
        logic signed [COORD_BITS:0] dx, dy;
        logic [COORD_BITS:0]        ax, ay;
        logic [DIST_BITS-1:0]       wx, wy;
        dx = {px[COORD_BITS-1], px} - {sx[COORD_BITS-1], sx};
        dy = {py[COORD_BITS-1], py} - {sy[COORD_BITS-1], sy};
        ax = dx[COORD_BITS] ? -dx : dx;
        ay = dy[COORD_BITS] ? -dy : dy;
        wx = DIST_BITS'(ax);
        wy = DIST_BITS'(ay);
        return wx * wx + wy * wy;
    endfunction

    function automatic t_out_item nearest_site_of(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py
    );
        int                   limit;
        int                   best;
        logic [DIST_BITS-1:0] best_d, d;
        t_out_item            r;
        limit = (search_count > MAX_SITES) ? MAX_SITES : int'(search_count);
        r.nearest_index = '0;
        r.no_sites      = 1'b0;
        if (limit == 0) begin
            r.no_sites = 1'b1;
            return r;
        end
        best   = 0;
        best_d = squared_gap(px, py, site_x[0], site_y[0]);
        for (int i = 1; i < limit; i++) begin
            d = squared_gap(px, py, site_x[i], site_y[i]);
            // strict compare: lowest index keeps a tie
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        r.nearest_index = INDEX_BITS'(best);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("nss check @%0t: %s", $time, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            search_count = '0;
            want_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                search_count = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (want_results.size() == 0) begin
                    flag_mismatch($sformatf("result item with none outstanding: index %0d flag %0b",
                                            i_out_item.nearest_index, i_out_item.no_sites));
                end else begin
                    want = want_results.pop_front();
                    if (i_out_item.nearest_index !== want.nearest_index) begin
                        flag_mismatch($sformatf("nearest_index got %0d want %0d",
                                                i_out_item.nearest_index, want.nearest_index));
                    end
                    if (i_out_item.no_sites !== want.no_sites) begin
                        flag_mismatch($sformatf("no_sites got %0b want %0b",
                                                i_out_item.no_sites, want.no_sites));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.func == FUNC_WRITE) begin
                    site_x[i_in_item.site_index] = i_in_item.coord_x;
                    site_y[i_in_item.site_index] = i_in_item.coord_y;
                end else begin
                    want_results.insert(want_results.size(),
                                        nearest_site_of(i_in_item.coord_x,
                                                        i_in_item.coord_y));
                end
            end
            o_pending <= want_results.size();
        end
    end

endmodule

// ----- sim/nearest_site_search_tb.sv -----
// Testbench top for nearest_site_search: resets the block, drives site writes,
// queries and count settings with random gaps and stalls, and gives the verdict.
// Depends on nss_pkg, the nearest_site_search RTL and nss_result_checker.
module nearest_site_search_tb;
    import nss_pkg::*;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_coord COORD_MIN     = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord COORD_MAX     = {1'b0, {(COORD_BITS-1){1'b1}}};
    // longest scan plus pipeline, with margin
    localparam int     SETTLE_CYCLES = MAX_SITES + 16;
    // no acceptance for this long means the block is stuck
    localparam int     IDLE_LIMIT    = 5000;
    localparam int     RANDOM_ITEMS  = 1800;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_item            in_item;
    logic                out_valid;
    logic                out_ready;
    t_out_item           out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CNT_BITS-1:0] cfg_data;
    int                  pending;
    int                  fail_count;

    // stimulus-side copy of what was written, used to aim queries and to
    // keep every searched entry written before a query reaches it
    t_coord stim_x [MAX_SITES];
    t_coord stim_y [MAX_SITES];
    bit     written [MAX_SITES];
    int     items_sent;
    bit     steady;
    int     idle_run;

    nearest_site_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    nss_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    // Return zero throughout a steady stretch.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Coordinate mix: extremes, a tight cluster that makes ties, full range.
    function automatic t_coord pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0:       return COORD_MIN;
                1:       return COORD_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end else if (r < 40) begin
            return t_coord'(int'($urandom_range(0, 8)) - 4);
        end
        return t_coord'($urandom);
    endfunction

    // Present one input item and hold it until accepted. Valid stays high on
    // return so a back-to-back item follows without a bubble.
    task automatic push_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (it.func == FUNC_WRITE) begin
            written[it.site_index] = 1'b1;
            stim_x[it.site_index]  = it.coord_x;
            stim_y[it.site_index]  = it.coord_y;
        end
    endtask

    task automatic write_site(input int idx, input t_coord x, input t_coord y);
        t_in_item it;
        it.func       = FUNC_WRITE;
        it.site_index = INDEX_BITS'(idx);
        it.coord_x    = x;
        it.coord_y    = y;
        push_item(it);
    endtask

    task automatic ask_nearest(input t_coord x, input t_coord y);
        t_in_item it;
        it.func       = FUNC_QUERY;
        it.site_index = INDEX_BITS'($urandom);  // unused by a query, toggle anyway
        it.coord_x    = x;
        it.coord_y    = y;
        push_item(it);
    endtask

    // Drop valid, wait out every outstanding result, then give the block time
    // to finish anything that produces no result.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write sites_in_use; only ever done with the block idle.
    task automatic write_count(input int count);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_BITS'(count);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write every missing entry below lim, in shuffled order.
    task automatic fill_table(input int lim);
        int missing [$];
        int j, tmp;
        for (int i = 0; i < lim; i++) begin
            if (!written[i]) missing.insert(missing.size(), i);
        end
        for (int i = missing.size() - 1; i > 0; i--) begin
            j          = $urandom_range(0, i);
            tmp        = missing[i];
            missing[i] = missing[j];
            missing[j] = tmp;
        end
        foreach (missing[k]) write_site(missing[k], pick_coord(), pick_coord());
    endtask

    // One setting of sites_in_use followed by a burst of writes and queries.
    task automatic run_phase(input int count);
        int     lim, n, k;
        t_coord x, y;
        lim    = (count > MAX_SITES) ? MAX_SITES : count;
        steady = ($urandom_range(0, 9) == 0);
        fill_table(lim);
        write_count(count);
        // long scans get few queries to keep the run short
        n = (lim > 64) ? $urandom_range(2, 8) : $urandom_range(10, 50);
        repeat (n) begin
            if ($urandom_range(0, 9) < 3) begin
                // rewrite inside the searched range mostly, anywhere otherwise
                if (lim > 0 && $urandom_range(0, 1)) begin
                    k = $urandom_range(0, lim - 1);
                end else begin
                    k = $urandom_range(0, MAX_SITES - 1);
                end
                write_site(k, pick_coord(), pick_coord());
            end else if (lim > 0 && $urandom_range(0, 9) < 3) begin
                // aim close to a stored site
                k = $urandom_range(0, lim - 1);
                x = stim_x[k] + t_coord'(int'($urandom_range(0, 6)) - 3);
                y = stim_y[k] + t_coord'(int'($urandom_range(0, 6)) - 3);
                ask_nearest(x, y);
            end else begin
                ask_nearest(pick_coord(), pick_coord());
            end
        end
    endtask

    // Receiver side: hold ready high for a while, then stall for a random gap.
    initial begin
        int hold, stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            hold  = $urandom_range(1, 8);
            stall = pick_gap();
            out_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles with no handshake on any channel.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_run <= 0;
        end else begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_run <= 0;
            end else begin
                idle_run <= idle_run + 1;
            end
            if (idle_run >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int start_items;
        int r;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        steady     = 1'b0;
        items_sent = 0;
        foreach (written[i]) written[i] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table straight out of reset.
        ask_nearest(COORD_MAX, COORD_MIN);

        // Directed: corner sites, a duplicate for a tie, and the top entry.
        write_site(0, COORD_MIN, COORD_MIN);
        write_site(1, COORD_MAX, COORD_MAX);
        write_site(2, '0, '0);
        write_site(3, '0, '0);
        write_site(MAX_SITES - 1, COORD_MAX, COORD_MIN);
        write_count(4);
        ask_nearest(COORD_MAX, COORD_MAX);  // farthest pair: widest distance
        ask_nearest(COORD_MIN, COORD_MIN);
        ask_nearest(t_coord'(1), t_coord'(1));  // equidistant from entries 2 and 3: lower wins
        ask_nearest(COORD_MAX, COORD_MIN);
        ask_nearest(COORD_MIN, COORD_MAX);

        // Directed: two sites equidistant from the opposite corners.
        write_count(2);
        ask_nearest(COORD_MAX, COORD_MIN);
        ask_nearest(COORD_MIN, COORD_MAX);

        // Directed: single site, then empty again by register.
        write_count(1);
        ask_nearest('0, '0);
        ask_nearest(COORD_MAX, COORD_MAX);
        write_count(0);
        ask_nearest('0, '0);

        // Random phases: mostly small tables, a few full scans.
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                run_phase(0);
            end else if (r < 60) begin
                run_phase($urandom_range(1, 16));
            end else if (r < 85) begin
                run_phase($urandom_range(17, 64));
            end else if (r < 95) begin
                run_phase($urandom_range(65, MAX_SITES - 1));
            end else begin
                run_phase($urandom_range(MAX_SITES, (1 << CNT_BITS) - 1));
            end
        end

        // Always visit the full table and the counts beyond it.
        run_phase(MAX_SITES);
        run_phase((1 << CNT_BITS) - 1);
        run_phase(MAX_SITES + 1);

        settle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
